// ----- rtl/rfh_pkg.sv -----
package rfh_pkg;

    localparam int BINS      = 256;
    localparam int BIN_W     = 8;
    localparam int COUNT_W   = 25;

    // Saturation bound of one bin count, held eight bits wider than a count
    // so that bounds at or above 2^25 never saturate.
    localparam logic [32:0] MAX_FRAME_PIXELS = 33'd16777216;

    // Item kinds on the input channel.
    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    // Add one to a bin count unless it has reached the frame-size bound.
    function automatic logic [COUNT_W-1:0] sat_bump(input logic [COUNT_W-1:0] count);
        logic [32:0] wide;
        wide = {{(33-COUNT_W){1'b0}}, count};
        if (wide < MAX_FRAME_PIXELS) begin
            sat_bump = count + {{(COUNT_W-1){1'b0}}, 1'b1};
        end else begin
            sat_bump = count;
        end
    endfunction

endpackage

// ----- rtl/rgb_frame_histogram.sv -----
// A pixel transfer reads its bins when accepted and writes the bumped counts back in
// modify; a readout transfer loads its result into the output register in modify.
// Items are taken only in idle, so no new item is accepted until the current one has
// finished the read-then-write of the bin memories. A readout also stays in modify
// while the previous result still waits on the m_ channel.
// Reset: aresetn is synchronous and active low; then a sweep clears the bins, no input.
module rgb_frame_histogram (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_kind,
    input  logic [rfh_pkg::BIN_W-1:0]   s_red,
    input  logic [rfh_pkg::BIN_W-1:0]   s_green,
    input  logic [rfh_pkg::BIN_W-1:0]   s_blue,
    input  logic [rfh_pkg::BIN_W-1:0]   s_bin,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rfh_pkg::BIN_W-1:0]   m_bin_index,
    output logic [rfh_pkg::COUNT_W-1:0] m_red_count,
    output logic [rfh_pkg::COUNT_W-1:0] m_green_count,
    output logic [rfh_pkg::COUNT_W-1:0] m_blue_count,
    output logic                        m_last_bin
);

    import rfh_pkg::*;

    // The block has three phases. After reset it clears the bin memories.
    // In idle it waits for an input transfer and issues the memory reads.
    // In modify the read data is back, a pixel writes the new counts, and a
    // readout clears its bin and loads the output register.
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_MODIFY = 3'b100
    } state_t;

    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(BINS - 1);

    state_t state_reg, state_next;
    logic [BIN_W-1:0] clr_cnt_reg, clr_cnt_next;

    // The accepted item: its kind and the bin address of each channel.
    logic             kind_reg;
    logic [BIN_W-1:0] red_addr_reg, green_addr_reg, blue_addr_reg;

    // Output register, which holds a result until its transfer completes.
    logic               m_valid_reg, m_valid_next;
    logic [BIN_W-1:0]   m_bin_index_reg;
    logic [COUNT_W-1:0] m_red_count_reg, m_green_count_reg, m_blue_count_reg;
    logic               m_last_bin_reg;

    logic               in_xfer;
    logic               out_free;
    logic               load_out;
    logic               finish;

    logic               mem_re;
    logic [BIN_W-1:0]   red_raddr, green_raddr, blue_raddr;
    logic               mem_we;
    logic [BIN_W-1:0]   red_waddr, green_waddr, blue_waddr;
    logic [COUNT_W-1:0] red_wdata, green_wdata, blue_wdata;
    logic [COUNT_W-1:0] red_rdata, green_rdata, blue_rdata;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // A pixel always finishes in modify. A readout waits there, with the
    // read data held in the memory output registers, until the output
    // register can take its result.
    assign finish   = (state_reg == ST_MODIFY) && ((kind_reg == KIND_PIXEL) || out_free);
    assign load_out = finish && (kind_reg == KIND_READOUT);

    // A readout reads the same bin in all three channels; a pixel reads the
    // bin of each channel value.
    assign mem_re      = in_xfer;
    assign red_raddr   = (s_kind == KIND_READOUT) ? s_bin : s_red;
    assign green_raddr = (s_kind == KIND_READOUT) ? s_bin : s_green;
    assign blue_raddr  = (s_kind == KIND_READOUT) ? s_bin : s_blue;

    always_comb begin
        mem_we      = 1'b0;
        red_waddr   = red_addr_reg;
        green_waddr = green_addr_reg;
        blue_waddr  = blue_addr_reg;
        red_wdata   = '0;
        green_wdata = '0;
        blue_wdata  = '0;
        if (state_reg == ST_CLEAR) begin
            mem_we      = 1'b1;
            red_waddr   = clr_cnt_reg;
            green_waddr = clr_cnt_reg;
            blue_waddr  = clr_cnt_reg;
        end else if (finish) begin
            mem_we = 1'b1;
            if (kind_reg == KIND_PIXEL) begin
                red_wdata   = sat_bump(red_rdata);
                green_wdata = sat_bump(green_rdata);
                blue_wdata  = sat_bump(blue_rdata);
            end
        end
    end

    rfh_bin_ram #(.DATA_W(COUNT_W), .ADDR_W(BIN_W)) u_red_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (red_waddr),
        .wdata (red_wdata),
        .re    (mem_re),
        .raddr (red_raddr),
        .rdata (red_rdata)
    );

    rfh_bin_ram #(.DATA_W(COUNT_W), .ADDR_W(BIN_W)) u_green_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (green_waddr),
        .wdata (green_wdata),
        .re    (mem_re),
        .raddr (green_raddr),
        .rdata (green_rdata)
    );

    rfh_bin_ram #(.DATA_W(COUNT_W), .ADDR_W(BIN_W)) u_blue_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (blue_waddr),
        .wdata (blue_wdata),
        .re    (mem_re),
        .raddr (blue_raddr),
        .rdata (blue_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + {{(BIN_W-1){1'b0}}, 1'b1};
                if (clr_cnt_reg == LAST_BIN) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = ST_MODIFY;
                end
            end
            ST_MODIFY: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            kind_reg       <= s_kind;
            red_addr_reg   <= red_raddr;
            green_addr_reg <= green_raddr;
            blue_addr_reg  <= blue_raddr;
        end
    end

    // Counts are reported plus one, wrapping in the 25-bit count width.
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_bin_index_reg   <= red_addr_reg;
            m_red_count_reg   <= red_rdata + {{(COUNT_W-1){1'b0}}, 1'b1};
            m_green_count_reg <= green_rdata + {{(COUNT_W-1){1'b0}}, 1'b1};
            m_blue_count_reg  <= blue_rdata + {{(COUNT_W-1){1'b0}}, 1'b1};
            m_last_bin_reg    <= (red_addr_reg == LAST_BIN);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_bin_index   = m_bin_index_reg;
    assign m_red_count   = m_red_count_reg;
    assign m_green_count = m_green_count_reg;
    assign m_blue_count  = m_blue_count_reg;
    assign m_last_bin    = m_last_bin_reg;

    // A new result appears only after a readout finished its modify cycle.
    a_result_from_readout: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_MODIFY && kind_reg == KIND_READOUT))
        else $error("result appeared without a finished readout");

    // Every reported count is at least one.
    a_counts_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_red_count != '0 && m_green_count != '0 && m_blue_count != '0))
        else $error("reported count is zero");

    // The clearing sweep counter moves only during the sweep.
    a_clear_counter_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_CLEAR) |=> $stable(clr_cnt_reg))
        else $error("clear counter moved outside the sweep");

    // A readout never overwrites a result that is still waiting.
    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !load_out)
        else $error("pending result overwritten");

endmodule

// ----- rtl/rfh_bin_ram.sv -----
module rfh_bin_ram #(
    parameter int DATA_W = rfh_pkg::COUNT_W,
    parameter int ADDR_W = rfh_pkg::BIN_W
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
